@@ sv/tsccr_pkg.sv @@
// shared types and constants for the continuity counter restamp block
package tsccr_pkg;

    localparam int PID_W           = 13;
    localparam int CC_W            = 4;
    localparam int EPOCH_W         = 8;
    localparam int PID_COUNT_DEF   = 8192;

    localparam logic [EPOCH_W-1:0] EPOCH_NONE  = '0;
    localparam logic [EPOCH_W-1:0] EPOCH_FIRST = EPOCH_W'(1);
    localparam logic [EPOCH_W-1:0] EPOCH_MAX   = '1;

    localparam logic DIR_FORWARD  = 1'b0;
    localparam logic DIR_BACKWARD = 1'b1;

    typedef struct packed {
        logic [EPOCH_W-1:0] tag;
        logic [CC_W-1:0]    cc;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    typedef enum logic [0:0] {
        ST_CLEAR = 1'b0,
        ST_RUN   = 1'b1
    } state_t;

endpackage

@@ sv/tsccr_ram.sv @@
// generic single write port, single read port ram with registered read
module tsccr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ sv/ts_continuity_counter_restamp_core.sv @@
// ts continuity counter restamp core: per-pid counter table with epoch-tagged entries
// pipeline: table read, then output register; clearing or a low out_ready stalls the input
// throughput: one transfer per cycle; repeated pids are forwarded from the write-back stage
// reset: direction clears to forward and a clearing pass writes every table entry, with
// in_ready low; the 255th new_run, then every 254th, triggers the same clearing pass
// before it is taken, as the 8-bit run epoch wraps
module ts_continuity_counter_restamp_core #(
    parameter int PID_COUNT = tsccr_pkg::PID_COUNT_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_wr_en,
    input  logic                       cfg_wr_data,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic [tsccr_pkg::PID_W-1:0] pid,
    input  logic [tsccr_pkg::CC_W-1:0]  counter_in,
    input  logic                       new_run,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic [tsccr_pkg::CC_W-1:0]  counter_out,
    output logic                       rewritten
);

    import tsccr_pkg::*;

    localparam int ADDR_W = $clog2(PID_COUNT);
    localparam logic [ADDR_W-1:0] ADDR_LAST = ADDR_W'(PID_COUNT - 1);

    state_t state_reg, state_next;
    logic   clearing;
    logic   wrap_start;

    logic [ADDR_W-1:0]  clr_addr_reg, clr_addr_next;
    logic [EPOCH_W-1:0] epoch_reg, epoch_next;
    logic               direction_reg;

    logic               in_accept;
    logic               in_range;
    logic               advance;
    logic               s1_writes;
    logic               fwd_match;

    logic               s1_valid_reg;
    logic               s1_in_range_reg;
    logic [ADDR_W-1:0]  s1_addr_reg;
    logic [CC_W-1:0]    s1_cc_in_reg;
    logic [EPOCH_W-1:0] s1_epoch_reg;
    logic               fwd_hit_reg;
    entry_t             fwd_entry_reg;

    entry_t             ram_rdata;
    entry_t             cur_entry;
    entry_t             new_entry;
    logic               seen;
    logic [CC_W-1:0]    cc_step;
    logic [CC_W-1:0]    cc_result;

    logic               ram_we;
    logic [ADDR_W-1:0]  ram_waddr;
    entry_t             ram_wdata;

    logic               out_valid_reg;
    logic [CC_W-1:0]    counter_out_reg;
    logic               rewritten_reg;

    // handshake and pipeline control
    assign in_range  = ({1'b0, pid} < (PID_W + 1)'(PID_COUNT));
    assign advance   = !out_valid_reg || out_ready;
    assign in_ready  = !clearing && !(new_run && epoch_reg == EPOCH_MAX)
                       && (!s1_valid_reg || advance);
    assign in_accept = in_valid && in_ready;
    assign s1_writes = s1_valid_reg && s1_in_range_reg && advance;
    assign fwd_match = s1_writes && in_range && (s1_addr_reg == pid[ADDR_W-1:0]);
    assign wrap_start = in_valid && new_run && (epoch_reg == EPOCH_MAX) && !s1_valid_reg;

    // fsm next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                if (clr_addr_reg == ADDR_LAST)
                begin
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                if (wrap_start)
                begin
                    state_next = ST_CLEAR;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    // fsm outputs
    always_comb
    begin
        case (state_reg)
            ST_CLEAR: clearing = 1'b1;
            ST_RUN:   clearing = 1'b0;
            default:  clearing = 1'b1;
        endcase
    end

    always_comb
    begin
        clr_addr_next = clr_addr_reg;
        if (clearing)
        begin
            clr_addr_next = clr_addr_reg + ADDR_W'(1);
        end
        else
        begin
            clr_addr_next = '0;
        end
    end

    always_comb
    begin
        epoch_next = epoch_reg;
        if (clearing && clr_addr_reg == ADDR_LAST)
        begin
            epoch_next = EPOCH_FIRST;
        end
        else if (in_accept && new_run)
        begin
            epoch_next = epoch_reg + EPOCH_W'(1);
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_addr_reg  <= '0;
            epoch_reg     <= EPOCH_NONE;
            direction_reg <= DIR_FORWARD;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            clr_addr_reg <= clr_addr_next;
            epoch_reg    <= epoch_next;
            if (cfg_wr_en)
            begin
                direction_reg <= cfg_wr_data;
            end
            if (in_accept)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (advance)
            begin
                out_valid_reg <= s1_valid_reg;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_in_range_reg <= in_range;
            s1_addr_reg     <= pid[ADDR_W-1:0];
            s1_cc_in_reg    <= counter_in;
            s1_epoch_reg    <= new_run ? (epoch_reg + EPOCH_W'(1)) : epoch_reg;
            fwd_hit_reg     <= fwd_match;
            fwd_entry_reg   <= new_entry;
        end
        if (advance && s1_valid_reg)
        begin
            counter_out_reg <= cc_result;
            rewritten_reg   <= seen;
        end
    end

    // read-modify-write of the table entry
    assign cur_entry = fwd_hit_reg ? fwd_entry_reg : ram_rdata;
    assign seen      = s1_in_range_reg && (cur_entry.tag == s1_epoch_reg);
    assign cc_step   = (direction_reg == DIR_BACKWARD) ? (cur_entry.cc - CC_W'(1))
                                                       : (cur_entry.cc + CC_W'(1));
    assign cc_result = seen ? cc_step : s1_cc_in_reg;

    always_comb
    begin
        new_entry.tag = s1_epoch_reg;
        new_entry.cc  = cc_result;
    end

    always_comb
    begin
        if (clearing)
        begin
            ram_we        = 1'b1;
            ram_waddr     = clr_addr_reg;
            ram_wdata.tag = EPOCH_NONE;
            ram_wdata.cc  = '0;
        end
        else
        begin
            ram_we    = s1_writes;
            ram_waddr = s1_addr_reg;
            ram_wdata = new_entry;
        end
    end

    tsccr_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (PID_COUNT)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (in_accept),
        .raddr (pid[ADDR_W-1:0]),
        .rdata (ram_rdata)
    );

    assign out_valid   = out_valid_reg;
    assign counter_out = counter_out_reg;
    assign rewritten   = rewritten_reg;

`ifndef NO_ASSERTIONS
    a_no_transfer_while_clearing: assert property (@(posedge clk) disable iff (!rst_n)
        clearing |-> !in_ready)
        else $error("input transfer possible during clearing pass");

    a_wrap_clear_drained: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RUN && state_next == ST_CLEAR) |-> !s1_valid_reg)
        else $error("clearing pass started with an item in flight");

    a_epoch_nonzero_in_run: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RUN) |-> (epoch_reg != EPOCH_NONE))
        else $error("reserved epoch in use while running");

    a_forward_taken: assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && fwd_match) |=> fwd_hit_reg)
        else $error("same-pid write-back not forwarded");

    a_no_write_while_stalled: assert property (@(posedge clk) disable iff (!rst_n)
        (!clearing && out_valid_reg && !out_ready) |-> !ram_we)
        else $error("table written while output is stalled");
`endif

endmodule
